>>> rtl/core/emcll_pkg.sv
`default_nettype none

package emcll_pkg;

  // default configuration of the block
  localparam int FREQ_WIDTH_DEF   = 35;
  localparam int DB_FRAC_BITS_DEF = 8;

  // fixed widths of the datapath
  localparam int FRAC_STEPS = 24;      // fraction bits of log2 from squaring
  localparam int M_W        = 31;      // normalized mantissa, Q1.30
  localparam int A_W        = 30;      // segment slope, signed Q.24
  localparam int X0_W       = 4;       // segment origin, whole decades
  localparam int B_W        = 32;      // segment offset, unsigned Q.24
  localparam int V_W        = 64;      // level before rounding, signed Q.48
  localparam int Q_POINT    = 48;      // fraction bits of that level
  localparam int OUT_W      = 17;      // limit_db width
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int OUT_MAX    = 65535;
  localparam int OUT_MIN    = -65536;

  // curve selector codes
  localparam logic [1:0] KIND_CS114 = 2'd0;
  localparam logic [1:0] KIND_RE102 = 2'd1;
  localparam logic [1:0] KIND_CE102 = 2'd2;

  // re102 platform codes, the remaining code falls back to the original curve
  localparam logic [1:0] PLAT_HELI     = 2'd0;
  localparam logic [1:0] PLAT_LARGE    = 2'd1;
  localparam logic [1:0] PLAT_ORIGINAL = 2'd2;

  // fixed point constants
  localparam longint ONE_Q24 = 64'sd16777216;
  localparam logic [30:0] LOG10_2_Q32 = 31'd1292913987;
  localparam longint SLOPE_HELI_LOW =
    (64'sd15645167628 * ONE_Q24 + 64'sd500000000) / 64'sd1000000000;
  localparam longint SLOPE_HIGH =
    (64'sd19953242857 * ONE_Q24 + 64'sd500000000) / 64'sd1000000000;
  localparam longint SLOPE_CE102 =
    (64'sd20012124942 * ONE_Q24 + 64'sd500000000) / 64'sd1000000000;
  localparam longint CS114_HIGH_SLOPE = (64'sd971 * ONE_Q24 + 64'sd50) / 64'sd100;
  localparam longint CS114_HIGH_BASE  = (64'sd13247 * ONE_Q24 + 64'sd50) / 64'sd100;

  // frequency break points in hertz
  localparam logic [63:0] F_10K  = 64'd10000;
  localparam logic [63:0] F_500K = 64'd500000;
  localparam logic [63:0] F_1M   = 64'd1000000;
  localparam logic [63:0] F_2M   = 64'd2000000;
  localparam logic [63:0] F_30M  = 64'd30000000;
  localparam logic [63:0] F_100M = 64'd100000000;
  localparam logic [63:0] F_18G  = 64'd18000000000;

  // curve segment selected for one item
  typedef enum logic [3:0] {
    SEG_ZERO       = 4'd0,
    SEG_FLAT_24    = 4'd1,
    SEG_FLAT_34    = 4'd2,
    SEG_FLAT_44    = 4'd3,
    SEG_FLAT_60    = 4'd4,
    SEG_FLAT_69    = 4'd5,
    SEG_FLAT_79    = 4'd6,
    SEG_FLAT_89    = 4'd7,
    SEG_CS_LOW     = 4'd8,
    SEG_CS_HIGH    = 4'd9,
    SEG_HELI_LOW   = 4'd10,
    SEG_RE_HIGH_24 = 4'd11,
    SEG_RE_HIGH_34 = 4'd12,
    SEG_RE_HIGH_44 = 4'd13,
    SEG_CE_LOW     = 4'd14
  } seg_t;

  // control traveling with each pipeline stage
  typedef struct packed {
    logic valid;
    seg_t seg;
  } ctrl_t;

  // level = a * (lg - x0) + b, a and b in Q.24, x0 in whole decades
  typedef struct packed {
    logic signed [A_W-1:0] a;
    logic [X0_W-1:0]       x0;
    logic [B_W-1:0]        b;
  } seg_param_t;

  function automatic seg_param_t seg_param(input seg_t s);
    seg_param_t p;
    p.a  = '0;
    p.x0 = '0;
    p.b  = '0;
    case (s)
      SEG_FLAT_24: begin
        p.b = B_W'(64'sd24 * ONE_Q24);
      end
      SEG_FLAT_34: begin
        p.b = B_W'(64'sd34 * ONE_Q24);
      end
      SEG_FLAT_44: begin
        p.b = B_W'(64'sd44 * ONE_Q24);
      end
      SEG_FLAT_60: begin
        p.b = B_W'(64'sd60 * ONE_Q24);
      end
      SEG_FLAT_69: begin
        p.b = B_W'(64'sd69 * ONE_Q24);
      end
      SEG_FLAT_79: begin
        p.b = B_W'(64'sd79 * ONE_Q24);
      end
      SEG_FLAT_89: begin
        p.b = B_W'(64'sd89 * ONE_Q24);
      end
      SEG_CS_LOW: begin
        p.a  = A_W'(64'sd20 * ONE_Q24);
        p.x0 = X0_W'(3);
        p.b  = B_W'(64'sd29 * ONE_Q24);
      end
      SEG_CS_HIGH: begin
        p.a  = A_W'(-CS114_HIGH_SLOPE);
        p.x0 = X0_W'(3);
        p.b  = B_W'(CS114_HIGH_BASE);
      end
      SEG_HELI_LOW: begin
        p.a  = A_W'(-SLOPE_HELI_LOW);
        p.x0 = X0_W'(4);
        p.b  = B_W'(64'sd60 * ONE_Q24);
      end
      SEG_RE_HIGH_24: begin
        p.a  = A_W'(SLOPE_HIGH);
        p.x0 = X0_W'(8);
        p.b  = B_W'(64'sd24 * ONE_Q24);
      end
      SEG_RE_HIGH_34: begin
        p.a  = A_W'(SLOPE_HIGH);
        p.x0 = X0_W'(8);
        p.b  = B_W'(64'sd34 * ONE_Q24);
      end
      SEG_RE_HIGH_44: begin
        p.a  = A_W'(SLOPE_HIGH);
        p.x0 = X0_W'(8);
        p.b  = B_W'(64'sd44 * ONE_Q24);
      end
      SEG_CE_LOW: begin
        p.a  = A_W'(-SLOPE_CE102);
        p.x0 = X0_W'(4);
        p.b  = B_W'(64'sd94 * ONE_Q24);
      end
      default: begin
        p.b = '0;
      end
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/emc_limit_line_evaluator.sv
`default_nettype none

// MIL-STD-461 style limit-line evaluator. Each transaction on the input stream carries a
// frequency in hertz (tdata) and a curve selector (tuser: 0 CS114, 1 RE102, 2 CE102, 3 gives
// 0 dB); the output stream returns the limit in signed dB with DB_FRAC_BITS fraction bits,
// saturated to 17 bits, one result per input in order. A zero frequency is taken as 1 Hz.
// The RE102 variant comes from the platform register (0 helicopter, 1 large aircraft,
// 2 or 3 original; reset 2), written through cfg_wr_en/cfg_wr_data. The user must write it
// only while no item is in flight; the block does not check. It takes one item every cycle
// while the skid buffer is free. Items pass two front stages (leading one, normalize), the
// 24 squaring stages that produce the log2 fraction bits, six back stages (log10 scaling,
// segment multiply, rounding) and an output register. Its one-entry skid buffer keeps the
// input side ready while a result waits; the pipeline stops only when both are full.

module emc_limit_line_evaluator #(
  parameter int FREQ_WIDTH   = emcll_pkg::FREQ_WIDTH_DEF,
  parameter int DB_FRAC_BITS = emcll_pkg::DB_FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [((FREQ_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // freq_hz
  input  wire logic [1:0]                           s_axis_tuser,  // kind
  // output stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [emcll_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // limit_db
  // platform register
  input  wire logic                                 cfg_wr_en,
  input  wire logic [1:0]                           cfg_wr_data
);

  localparam int POS_W = $clog2(FREQ_WIDTH);
  localparam int STEPS = emcll_pkg::FRAC_STEPS;

  logic                                  en;
  logic [1:0]                            platform;

  emcll_pkg::ctrl_t                      sq_ctrl [0:STEPS];
  logic [POS_W-1:0]                      sq_pos  [0:STEPS];
  logic [emcll_pkg::M_W-1:0]             sq_m    [0:STEPS];
  logic [STEPS-1:0]                      sq_frac [0:STEPS];

  emcll_pkg::ctrl_t                      bk_ctrl;
  logic [emcll_pkg::OUT_W-1:0]           bk_res;

  logic                                  out_valid;
  logic [emcll_pkg::OUT_W-1:0]           out_res;
  logic                                  skid_valid;
  logic [emcll_pkg::OUT_W-1:0]           skid_res;
  logic                                  take;

  // pipeline advances while the skid buffer is free
  assign en            = !skid_valid;
  assign s_axis_tready = en;

  // platform register
  always_ff @(posedge clk) begin
    if (rst) begin
      platform <= emcll_pkg::PLAT_ORIGINAL;
    end else if (cfg_wr_en) begin
      platform <= cfg_wr_data;
    end
  end

  // leading one and normalization
  emcll_front #(
    .FREQ_WIDTH (FREQ_WIDTH),
    .POS_W      (POS_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .kind     (s_axis_tuser),
    .freq_hz  (s_axis_tdata[FREQ_WIDTH-1:0]),
    .platform (platform),
    .ctrl_o   (sq_ctrl[0]),
    .pos_o    (sq_pos[0]),
    .m_o      (sq_m[0])
  );

  assign sq_frac[0] = '0;

  // one log2 fraction bit per stage
  for (genvar g = 0; g < STEPS; g++) begin : g_sq
    emcll_sq_step #(
      .POS_W (POS_W)
    ) u_step (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctrl_i (sq_ctrl[g]),
      .pos_i  (sq_pos[g]),
      .m_i    (sq_m[g]),
      .frac_i (sq_frac[g]),
      .ctrl_o (sq_ctrl[g+1]),
      .pos_o  (sq_pos[g+1]),
      .m_o    (sq_m[g+1]),
      .frac_o (sq_frac[g+1])
    );
  end

  // log10 scaling and segment evaluation
  emcll_back #(
    .POS_W        (POS_W),
    .DB_FRAC_BITS (DB_FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .ctrl_i (sq_ctrl[STEPS]),
    .pos_i  (sq_pos[STEPS]),
    .frac_i (sq_frac[STEPS]),
    .ctrl_o (bk_ctrl),
    .res_o  (bk_res)
  );

  // output register with skid buffer
  assign take = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= bk_ctrl.valid;
      end
    end else if (en && bk_ctrl.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= skid_valid ? skid_res : bk_res;
    end else if (en) begin
      skid_res <= bk_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = emcll_pkg::OUT_TDATA_W'(out_res);

endmodule

`default_nettype wire

>>> rtl/core/emcll_front.sv
`default_nettype none

module emcll_front #(
  parameter int FREQ_WIDTH = emcll_pkg::FREQ_WIDTH_DEF,
  parameter int POS_W      = $clog2(FREQ_WIDTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [1:0]                 kind,
  input  wire logic [FREQ_WIDTH-1:0]      freq_hz,
  input  wire logic [1:0]                 platform,
  output emcll_pkg::ctrl_t                ctrl_o,
  output logic [POS_W-1:0]                pos_o,
  output logic [emcll_pkg::M_W-1:0]       m_o
);

  emcll_pkg::seg_t         seg_sel;
  logic [FREQ_WIDTH-1:0]   fz;
  logic [63:0]             f64;
  logic [POS_W-1:0]        pos_sel;

  // stage one registers
  emcll_pkg::ctrl_t        ctrl1;
  logic [FREQ_WIDTH-1:0]   f1;
  logic [POS_W-1:0]        pos1;

  // normalization
  logic [POS_W-1:0]        shamt;
  logic [FREQ_WIDTH-1:0]   norm;
  logic [FREQ_WIDTH+emcll_pkg::M_W-1:0] norm_ext;

  // zero frequency counts as 1 Hz
  assign fz  = (freq_hz == '0) ? FREQ_WIDTH'(1) : freq_hz;
  assign f64 = 64'(fz);

  // leading one position
  always_comb begin
    pos_sel = '0;
    for (int i = 0; i < FREQ_WIDTH; i++) begin
      if (fz[i]) begin
        pos_sel = POS_W'(i);
      end
    end
  end

  // pick the curve segment from the break points
  always_comb begin
    seg_sel = emcll_pkg::SEG_ZERO;
    case (kind)
      emcll_pkg::KIND_CS114: begin
        if (f64 < emcll_pkg::F_1M) begin
          seg_sel = emcll_pkg::SEG_CS_LOW;
        end else if (f64 <= emcll_pkg::F_30M) begin
          seg_sel = emcll_pkg::SEG_FLAT_89;
        end else begin
          seg_sel = emcll_pkg::SEG_CS_HIGH;
        end
      end
      emcll_pkg::KIND_RE102: begin
        case (platform)
          emcll_pkg::PLAT_HELI: begin
            if (f64 <= emcll_pkg::F_10K) begin
              seg_sel = emcll_pkg::SEG_FLAT_60;
            end else if (f64 < emcll_pkg::F_2M) begin
              seg_sel = emcll_pkg::SEG_HELI_LOW;
            end else if (f64 <= emcll_pkg::F_100M) begin
              seg_sel = emcll_pkg::SEG_FLAT_24;
            end else if (f64 >= emcll_pkg::F_18G) begin
              seg_sel = emcll_pkg::SEG_FLAT_69;
            end else begin
              seg_sel = emcll_pkg::SEG_RE_HIGH_24;
            end
          end
          emcll_pkg::PLAT_LARGE: begin
            if (f64 <= emcll_pkg::F_100M) begin
              seg_sel = emcll_pkg::SEG_FLAT_44;
            end else if (f64 >= emcll_pkg::F_18G) begin
              seg_sel = emcll_pkg::SEG_FLAT_89;
            end else begin
              seg_sel = emcll_pkg::SEG_RE_HIGH_44;
            end
          end
          default: begin
            if (f64 <= emcll_pkg::F_100M) begin
              seg_sel = emcll_pkg::SEG_FLAT_34;
            end else if (f64 >= emcll_pkg::F_18G) begin
              seg_sel = emcll_pkg::SEG_FLAT_79;
            end else begin
              seg_sel = emcll_pkg::SEG_RE_HIGH_34;
            end
          end
        endcase
      end
      emcll_pkg::KIND_CE102: begin
        if (f64 >= emcll_pkg::F_500K) begin
          seg_sel = emcll_pkg::SEG_FLAT_60;
        end else begin
          seg_sel = emcll_pkg::SEG_CE_LOW;
        end
      end
      default: begin
        seg_sel = emcll_pkg::SEG_ZERO;
      end
    endcase
  end

  // stage one: segment, frequency, leading one
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1.valid <= 1'b0;
    end else if (en) begin
      ctrl1.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl1.seg <= seg_sel;
      f1        <= fz;
      pos1      <= pos_sel;
    end
  end

  // bring the leading one to the top, keep the upper 31 bits (Q1.30)
  assign shamt    = POS_W'(FREQ_WIDTH - 1) - pos1;
  assign norm     = f1 << shamt;
  assign norm_ext = {norm, {emcll_pkg::M_W{1'b0}}};

  // stage two: normalized mantissa
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_o.valid <= 1'b0;
    end else if (en) begin
      ctrl_o.valid <= ctrl1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_o.seg <= ctrl1.seg;
      pos_o      <= pos1;
      m_o        <= norm_ext[FREQ_WIDTH+emcll_pkg::M_W-1 -: emcll_pkg::M_W];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/emcll_sq_step.sv
`default_nettype none

module emcll_sq_step #(
  parameter int POS_W = 6
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire emcll_pkg::ctrl_t                  ctrl_i,
  input  wire logic [POS_W-1:0]                  pos_i,
  input  wire logic [emcll_pkg::M_W-1:0]         m_i,
  input  wire logic [emcll_pkg::FRAC_STEPS-1:0]  frac_i,
  output emcll_pkg::ctrl_t                       ctrl_o,
  output logic [POS_W-1:0]                       pos_o,
  output logic [emcll_pkg::M_W-1:0]              m_o,
  output logic [emcll_pkg::FRAC_STEPS-1:0]       frac_o
);

  logic [2*emcll_pkg::M_W-1:0] sq;
  logic [emcll_pkg::M_W:0]     sq_q30;
  logic                        bit_out;

  // square in Q1.30, a result at or above 2 yields a one bit and halves
  assign sq      = (2*emcll_pkg::M_W)'(m_i) * (2*emcll_pkg::M_W)'(m_i);
  assign sq_q30  = sq[emcll_pkg::M_W-1 +: emcll_pkg::M_W+1];
  assign bit_out = sq_q30[emcll_pkg::M_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_o.valid <= 1'b0;
    end else if (en) begin
      ctrl_o.valid <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_o.seg <= ctrl_i.seg;
      pos_o      <= pos_i;
      m_o        <= bit_out ? sq_q30[emcll_pkg::M_W:1] : sq_q30[emcll_pkg::M_W-1:0];
      frac_o     <= {frac_i[emcll_pkg::FRAC_STEPS-2:0], bit_out};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/emcll_back.sv
`default_nettype none

module emcll_back #(
  parameter int POS_W        = 6,
  parameter int DB_FRAC_BITS = emcll_pkg::DB_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire emcll_pkg::ctrl_t                  ctrl_i,
  input  wire logic [POS_W-1:0]                  pos_i,
  input  wire logic [emcll_pkg::FRAC_STEPS-1:0]  frac_i,
  output emcll_pkg::ctrl_t                       ctrl_o,
  output logic [emcll_pkg::OUT_W-1:0]            res_o
);

  localparam int L2W   = POS_W + emcll_pkg::FRAC_STEPS;  // log2, Q.24
  localparam int PW1   = L2W + 31;                       // log2 * log10(2), Q.56
  localparam int LGW   = L2W - 1;                        // log10, Q.24
  localparam int DW    = LGW + 1;                        // log10 - x0, signed
  localparam int PW2   = DW + emcll_pkg::A_W;            // slope product, Q.48
  localparam int SHIFT = emcll_pkg::Q_POINT - DB_FRAC_BITS;
  localparam logic [PW1:0] RND1 = (PW1+1)'(64'd1 << 31);
  localparam logic signed [emcll_pkg::V_W-1:0] RND2 =
    emcll_pkg::V_W'(64'sd1 <<< (SHIFT - 1));
  localparam logic signed [emcll_pkg::V_W-1:0] SAT_HI = emcll_pkg::V_W'(emcll_pkg::OUT_MAX);
  localparam logic signed [emcll_pkg::V_W-1:0] SAT_LO = emcll_pkg::V_W'(emcll_pkg::OUT_MIN);

  emcll_pkg::ctrl_t c1, c2, c3, c4, c5;

  logic [L2W-1:0]                        log2_val;
  logic [PW1-1:0]                        prod1;
  logic [PW1:0]                          rsum;
  logic [LGW-1:0]                        lg;
  emcll_pkg::seg_param_t                 sp3, sp4, sp5;
  logic signed [DW-1:0]                  x0_q;
  logic signed [DW-1:0]                  d;
  logic signed [emcll_pkg::A_W-1:0]      slope;
  logic signed [PW2-1:0]                 prod2;
  logic signed [emcll_pkg::V_W-1:0]      b_term;
  logic signed [emcll_pkg::V_W-1:0]      lvl;
  logic signed [emcll_pkg::V_W-1:0]      lvl_rnd;
  logic signed [emcll_pkg::V_W-1:0]      lvl_db;

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      c1.valid     <= 1'b0;
      c2.valid     <= 1'b0;
      c3.valid     <= 1'b0;
      c4.valid     <= 1'b0;
      c5.valid     <= 1'b0;
      ctrl_o.valid <= 1'b0;
    end else if (en) begin
      c1.valid     <= ctrl_i.valid;
      c2.valid     <= c1.valid;
      c3.valid     <= c2.valid;
      c4.valid     <= c3.valid;
      c5.valid     <= c4.valid;
      ctrl_o.valid <= c5.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1.seg     <= ctrl_i.seg;
      c2.seg     <= c1.seg;
      c3.seg     <= c2.seg;
      c4.seg     <= c3.seg;
      c5.seg     <= c4.seg;
      ctrl_o.seg <= c5.seg;
    end
  end

  // segment constants at the stages that use them
  assign sp3    = emcll_pkg::seg_param(c2.seg);
  assign sp4    = emcll_pkg::seg_param(c3.seg);
  assign sp5    = emcll_pkg::seg_param(c4.seg);
  assign x0_q   = DW'({sp3.x0, 24'd0});
  assign slope  = sp4.a;
  assign b_term = $signed({8'd0, sp5.b, 24'd0});

  assign log2_val = {pos_i, frac_i};
  assign rsum     = {1'b0, prod1} + RND1;

  // round and saturate to the output format
  assign lvl_rnd = lvl + RND2;
  assign lvl_db  = lvl_rnd >>> SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      // log2 times log10(2)
      prod1 <= PW1'(log2_val) * PW1'(emcll_pkg::LOG10_2_Q32);
      // round to Q.24
      lg    <= rsum[32 +: LGW];
      // distance from segment origin
      d     <= $signed({1'b0, lg}) - x0_q;
      // slope term
      prod2 <= slope * d;
      // add segment offset
      lvl   <= emcll_pkg::V_W'(prod2) + b_term;
      if (lvl_db > SAT_HI) begin
        res_o <= emcll_pkg::OUT_W'(SAT_HI);
      end else if (lvl_db < SAT_LO) begin
        res_o <= emcll_pkg::OUT_W'(SAT_LO);
      end else begin
        res_o <= lvl_db[emcll_pkg::OUT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire
